// ----- src/irdp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helpers for the image resize dimension planner.
// Used by the front end, back end and top level; depends on nothing.
package irdp_pkg;

    localparam int FACTOR_BITS  = 8;
    localparam int AREA_BITS    = 26;
    localparam int SIDE_BITS    = 16;
    localparam int CFG_IDX_BITS = 2;
    localparam int MAX_ASPECT   = 200;

    localparam logic [SIDE_BITS-1:0] SIDE_SAT = 16'hFFFF;

    localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_FACTOR = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_AREA    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_AREA    = 2'd2;

    localparam logic [FACTOR_BITS-1:0] RESET_FACTOR   = 8'd28;
    localparam logic [AREA_BITS-1:0]   RESET_MIN_AREA = 26'd3136;
    localparam logic [AREA_BITS-1:0]   RESET_MAX_AREA = 26'd12845056;

    typedef enum logic [1:0]
    {
        MODE_KEEP   = 2'd0,
        MODE_SHRINK = 2'd1,
        MODE_GROW   = 2'd2
    } mode_t;

    typedef struct packed
    {
        logic [FACTOR_BITS-1:0] factor;
        logic [AREA_BITS-1:0]   min_area;
        logic [AREA_BITS-1:0]   max_area;
    } cfg_t;

    function automatic logic [SIDE_BITS-1:0] sat_side(input logic [31:0] v);
        if (v > 32'(SIDE_SAT))
        begin
            return SIDE_SAT;
        end
        return v[SIDE_BITS-1:0];
    endfunction

    function automatic logic [FACTOR_BITS-1:0] eff_factor(input logic [FACTOR_BITS-1:0] f);
        if (f == '0)
        begin
            return FACTOR_BITS'(1);
        end
        return f;
    endfunction

endpackage

// ----- src/irdp_div.sv -----
`timescale 1ns / 1ps
// Pipelined restoring divider: one quotient bit per stage, one item per cycle while en is high.
// Carries a side payload alongside; no package dependencies.
module irdp_div #(
    parameter int NW = 16,
    parameter int DW = 8,
    parameter int PW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [PW-1:0] pay,
    output logic          out_valid,
    output logic [NW-1:0] quo,
    output logic [DW-1:0] rem,
    output logic [PW-1:0] out_pay
);

    logic [NW+DW-1:0] acc_reg [0:NW];
    logic [DW-1:0]    den_reg [0:NW];
    logic [PW-1:0]    pay_reg [0:NW];
    logic             vld_reg [0:NW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            acc_reg[0] <= {{DW{1'b0}}, num};
            den_reg[0] <= den;
            pay_reg[0] <= pay;
        end
    end

    for (genvar k = 0; k < NW; k++)
    begin : g_step
        logic [DW:0]      top;
        logic [DW:0]      diff;
        logic             ge;
        logic [NW+DW-1:0] acc_next;

        always_comb
        begin
            top  = acc_reg[k][NW+DW-1:NW-1];
            diff = top - {1'b0, den_reg[k]};
            ge   = (top >= {1'b0, den_reg[k]});
            if (ge)
            begin
                acc_next = {diff[DW-1:0], acc_reg[k][NW-2:0], 1'b1};
            end
            else
            begin
                acc_next = {top[DW-1:0], acc_reg[k][NW-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                acc_reg[k+1] <= acc_next;
                den_reg[k+1] <= den_reg[k];
                pay_reg[k+1] <= pay_reg[k];
            end
        end
    end

    assign out_valid = vld_reg[NW];
    assign quo       = acc_reg[NW][NW-1:0];
    assign rem       = acc_reg[NW][NW+DW-1:NW];
    assign out_pay   = pay_reg[NW];

endmodule

// ----- src/irdp_sqrt.sv -----
`timescale 1ns / 1ps
// Pipelined integer square root: one root bit per stage, one item per cycle while en is high.
// Gives floor root and remainder; no package dependencies.
module irdp_sqrt #(
    parameter int W  = 40,
    parameter int PW = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [W-1:0]    val,
    input  logic [PW-1:0]   pay,
    output logic            out_valid,
    output logic [W/2-1:0]  root,
    output logic [W/2+1:0]  rem,
    output logic [PW-1:0]   out_pay
);

    localparam int RB = W / 2;

    logic [W-1:0]    val_reg  [0:RB];
    logic [RB+1:0]   rem_reg  [0:RB];
    logic [RB-1:0]   root_reg [0:RB];
    logic [PW-1:0]   pay_reg  [0:RB];
    logic            vld_reg  [0:RB];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            val_reg[0]  <= val;
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            pay_reg[0]  <= pay;
        end
    end

    for (genvar k = 0; k < RB; k++)
    begin : g_step
        logic [RB+1:0] shifted;
        logic [RB+1:0] trial;
        logic          ge;
        logic [RB+1:0] rem_next;
        logic [RB-1:0] root_next;

        always_comb
        begin
            shifted   = {rem_reg[k][RB-1:0], val_reg[k][W-1:W-2]};
            trial     = {root_reg[k], 2'b01};
            ge        = (shifted >= trial);
            rem_next  = ge ? (shifted - trial) : shifted;
            root_next = {root_reg[k][RB-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                val_reg[k+1]  <= {val_reg[k][W-3:0], 2'b00};
                rem_reg[k+1]  <= rem_next;
                root_reg[k+1] <= root_next;
                pay_reg[k+1]  <= pay_reg[k];
            end
        end
    end

    assign out_valid = vld_reg[RB];
    assign root      = root_reg[RB];
    assign rem       = rem_reg[RB];
    assign out_pay   = pay_reg[RB];

endmodule

// ----- src/irdp_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts items, flags bad shapes, rounds each side to the grid and
// picks keep, shrink or grow from the area. Uses irdp_pkg and irdp_div.
module irdp_front
    import irdp_pkg::*;
#(
    parameter int DIM_BITS = 14
) (
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [DIM_BITS-1:0] in_h,
    input  logic [DIM_BITS-1:0] in_w,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [DIM_BITS-1:0] out_h,
    output logic [DIM_BITS-1:0] out_w,
    output logic                out_bad,
    output mode_t               out_mode,
    output logic [DIM_BITS:0]   out_hb,
    output logic [DIM_BITS:0]   out_wb
);

    localparam int HB = DIM_BITS + 1;
    localparam int AB = 2 * HB;
    localparam int CW = (AB > AREA_BITS) ? AB : AREA_BITS;

    logic                   fen;
    logic [FACTOR_BITS-1:0] f;
    logic [DIM_BITS-1:0]    big;
    logic [DIM_BITS-1:0]    small_side;
    logic [DIM_BITS+7:0]    lim;
    logic                   bad_in;

    logic                   dv;
    logic [DIM_BITS-1:0]    qh;
    logic [DIM_BITS-1:0]    qw;
    logic [FACTOR_BITS-1:0] rh;
    logic [FACTOR_BITS-1:0] rw;
    logic [DIM_BITS:0]      pay_h;
    logic [DIM_BITS-1:0]    pay_w;

    logic                   vr_reg;
    logic [HB-1:0]          hb_reg;
    logic [HB-1:0]          wb_reg;
    logic [DIM_BITS-1:0]    h_r_reg;
    logic [DIM_BITS-1:0]    w_r_reg;
    logic                   bad_r_reg;

    logic                   va_reg;
    logic [AB-1:0]          area_reg;
    logic [HB-1:0]          hb_a_reg;
    logic [HB-1:0]          wb_a_reg;
    logic [DIM_BITS-1:0]    h_a_reg;
    logic [DIM_BITS-1:0]    w_a_reg;
    logic                   bad_a_reg;

    function automatic logic [HB-1:0] round_side(
        input logic [DIM_BITS-1:0]    q,
        input logic [FACTOR_BITS-1:0] r,
        input logic [FACTOR_BITS-1:0] fac
    );
        logic [FACTOR_BITS:0]          r2;
        logic                          up;
        logic [DIM_BITS:0]             qq;
        logic [DIM_BITS+FACTOR_BITS:0] prod;
        r2   = {r, 1'b0};
        up   = (r2 > {1'b0, fac}) || ((r2 == {1'b0, fac}) && q[0]);
        qq   = {1'b0, q} + (DIM_BITS+1)'(up);
        prod = (DIM_BITS+FACTOR_BITS+1)'(qq) * (DIM_BITS+FACTOR_BITS+1)'(fac);
        if (prod < (DIM_BITS+FACTOR_BITS+1)'(fac))
        begin
            prod = (DIM_BITS+FACTOR_BITS+1)'(fac);
        end
        return prod[HB-1:0];
    endfunction

    assign fen      = !va_reg || out_ready;
    assign in_ready = fen;
    assign f        = eff_factor(cfg.factor);

    always_comb
    begin
        big        = (in_h > in_w) ? in_h : in_w;
        small_side = (in_h > in_w) ? in_w : in_h;
        lim        = (DIM_BITS+8)'(small_side) * (DIM_BITS+8)'(MAX_ASPECT);
        bad_in     = (small_side == '0) || ((DIM_BITS+8)'(big) > lim);
    end

    irdp_div #(.NW(DIM_BITS), .DW(FACTOR_BITS), .PW(DIM_BITS+1)) u_div_h (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (fen),
        .in_valid  (in_valid),
        .num       (in_h),
        .den       (f),
        .pay       ({bad_in, in_h}),
        .out_valid (dv),
        .quo       (qh),
        .rem       (rh),
        .out_pay   (pay_h)
    );

    irdp_div #(.NW(DIM_BITS), .DW(FACTOR_BITS), .PW(DIM_BITS)) u_div_w (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (fen),
        .in_valid  (in_valid),
        .num       (in_w),
        .den       (f),
        .pay       (in_w),
        .out_valid (),
        .quo       (qw),
        .rem       (rw),
        .out_pay   (pay_w)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vr_reg <= 1'b0;
            va_reg <= 1'b0;
        end
        else if (fen)
        begin
            vr_reg <= dv;
            va_reg <= vr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fen)
        begin
            hb_reg    <= round_side(qh, rh, f);
            wb_reg    <= round_side(qw, rw, f);
            h_r_reg   <= pay_h[DIM_BITS-1:0];
            w_r_reg   <= pay_w;
            bad_r_reg <= pay_h[DIM_BITS];
            area_reg  <= AB'(hb_reg) * AB'(wb_reg);
            hb_a_reg  <= hb_reg;
            wb_a_reg  <= wb_reg;
            h_a_reg   <= h_r_reg;
            w_a_reg   <= w_r_reg;
            bad_a_reg <= bad_r_reg;
        end
    end

    always_comb
    begin
        if (CW'(area_reg) > CW'(cfg.max_area))
        begin
            out_mode = MODE_SHRINK;
        end
        else if (CW'(area_reg) < CW'(cfg.min_area))
        begin
            out_mode = MODE_GROW;
        end
        else
        begin
            out_mode = MODE_KEEP;
        end
    end

    assign out_valid = va_reg;
    assign out_h     = h_a_reg;
    assign out_w     = w_a_reg;
    assign out_bad   = bad_a_reg;
    assign out_hb    = hb_a_reg;
    assign out_wb    = wb_a_reg;

endmodule

// ----- src/irdp_fifo.sv -----
`timescale 1ns / 1ps
// Four-entry queue between the front and back ends.
// Plain register storage; no package dependencies.
module irdp_fifo #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [W-1:0] in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [W-1:0] out_data
);

    localparam int DEPTH = 4;
    localparam int PB    = $clog2(DEPTH);

    logic [W-1:0] mem_reg [0:DEPTH-1];
    logic [PB-1:0] wptr_reg;
    logic [PB-1:0] rptr_reg;
    logic [PB:0]   cnt_reg;
    logic          push;
    logic          pop;

    assign in_ready  = (cnt_reg != (PB+1)'(DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = mem_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= in_data;
        end
    end

endmodule

// ----- src/irdp_back.sv -----
`timescale 1ns / 1ps
// Back end: scales both sides by the square root of the area ratio where needed,
// snaps them to the grid and saturates. Uses irdp_pkg, irdp_div and irdp_sqrt.
module irdp_back
    import irdp_pkg::*;
#(
    parameter int DIM_BITS = 14
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cfg_t                 cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [DIM_BITS-1:0]  in_h,
    input  logic [DIM_BITS-1:0]  in_w,
    input  logic                 in_bad,
    input  mode_t                in_mode,
    input  logic [DIM_BITS:0]    in_hb,
    input  logic [DIM_BITS:0]    in_wb,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [SIDE_BITS-1:0] out_height,
    output logic [SIDE_BITS-1:0] out_width,
    output logic                 out_bad
);

    localparam int HB  = DIM_BITS + 1;
    localparam int PB  = DIM_BITS + AREA_BITS;
    localparam int SW  = PB + (PB % 2);
    localparam int RB  = SW / 2;
    localparam int MB  = RB + 1;
    localparam int PAY = 3 + 2 * HB;

    logic                   ben;
    logic [FACTOR_BITS-1:0] f;

    logic                   v0_reg;
    logic [PB-1:0]          ph_reg;
    logic [PB-1:0]          pw_reg;
    logic [DIM_BITS-1:0]    h0_reg;
    logic [DIM_BITS-1:0]    w0_reg;
    logic [PAY-1:0]         pay0_reg;
    logic [AREA_BITS-1:0]   area_sel;
    logic                   grow0;
    logic [PB-1:0]          num_h;
    logic [PB-1:0]          num_w;

    logic                   dv1;
    logic [PB-1:0]          qh1;
    logic [PB-1:0]          qw1;
    logic [PAY-1:0]         pay1;

    logic                   sv;
    logic [RB-1:0]          rooth;
    logic [RB-1:0]          rootw;
    logic [RB+1:0]          remh;
    logic [RB+1:0]          remw;
    logic [PAY-1:0]         pay2;
    logic                   grow2;
    logic [MB-1:0]          mh;
    logic [MB-1:0]          mw;
    logic [MB-1:0]          nh;
    logic [MB-1:0]          nw;

    logic                   dv3;
    logic [MB-1:0]          qh3;
    logic [MB-1:0]          qw3;
    logic [PAY-1:0]         pay3;
    mode_t                  mode3;
    logic [31:0]            resh;
    logic [31:0]            resw;

    logic                   ov_reg;
    logic [SIDE_BITS-1:0]   oh_reg;
    logic [SIDE_BITS-1:0]   ow_reg;
    logic                   ob_reg;
    logic [SIDE_BITS-1:0]   oh_next;
    logic [SIDE_BITS-1:0]   ow_next;

    assign ben      = !ov_reg || out_ready;
    assign in_ready = ben;
    assign f        = eff_factor(cfg.factor);
    assign area_sel = (in_mode == MODE_GROW) ? cfg.min_area : cfg.max_area;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else if (ben)
        begin
            v0_reg <= in_valid;
            ov_reg <= dv3;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ben)
        begin
            ph_reg   <= PB'(in_h) * PB'(area_sel);
            pw_reg   <= PB'(in_w) * PB'(area_sel);
            h0_reg   <= in_h;
            w0_reg   <= in_w;
            pay0_reg <= {in_bad, in_mode, in_hb, in_wb};
            oh_reg   <= oh_next;
            ow_reg   <= ow_next;
            ob_reg   <= pay3[PAY-1];
        end
    end

    always_comb
    begin
        grow0 = (mode_t'(pay0_reg[PAY-2:PAY-3]) == MODE_GROW);
        num_h = ph_reg + (grow0 ? PB'(w0_reg - 1'b1) : '0);
        num_w = pw_reg + (grow0 ? PB'(h0_reg - 1'b1) : '0);
    end

    irdp_div #(.NW(PB), .DW(DIM_BITS), .PW(PAY)) u_div_h (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (ben),
        .in_valid  (v0_reg),
        .num       (num_h),
        .den       (w0_reg),
        .pay       (pay0_reg),
        .out_valid (dv1),
        .quo       (qh1),
        .rem       (),
        .out_pay   (pay1)
    );

    irdp_div #(.NW(PB), .DW(DIM_BITS), .PW(1)) u_div_w (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (ben),
        .in_valid  (v0_reg),
        .num       (num_w),
        .den       (h0_reg),
        .pay       (1'b0),
        .out_valid (),
        .quo       (qw1),
        .rem       (),
        .out_pay   ()
    );

    irdp_sqrt #(.W(SW), .PW(PAY)) u_sqrt_h (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (ben),
        .in_valid  (dv1),
        .val       (SW'(qh1)),
        .pay       (pay1),
        .out_valid (sv),
        .root      (rooth),
        .rem       (remh),
        .out_pay   (pay2)
    );

    irdp_sqrt #(.W(SW), .PW(1)) u_sqrt_w (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (ben),
        .in_valid  (dv1),
        .val       (SW'(qw1)),
        .pay       (1'b0),
        .out_valid (),
        .root      (rootw),
        .rem       (remw),
        .out_pay   ()
    );

    always_comb
    begin
        grow2 = (mode_t'(pay2[PAY-2:PAY-3]) == MODE_GROW);
        mh    = MB'(rooth) + MB'(grow2 && (remh != '0));
        mw    = MB'(rootw) + MB'(grow2 && (remw != '0));
        nh    = grow2 ? (mh + MB'(f) - 1'b1) : mh;
        nw    = grow2 ? (mw + MB'(f) - 1'b1) : mw;
    end

    irdp_div #(.NW(MB), .DW(FACTOR_BITS), .PW(PAY)) u_snap_h (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (ben),
        .in_valid  (sv),
        .num       (nh),
        .den       (f),
        .pay       (pay2),
        .out_valid (dv3),
        .quo       (qh3),
        .rem       (),
        .out_pay   (pay3)
    );

    irdp_div #(.NW(MB), .DW(FACTOR_BITS), .PW(1)) u_snap_w (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (ben),
        .in_valid  (sv),
        .num       (nw),
        .den       (f),
        .pay       (1'b0),
        .out_valid (),
        .quo       (qw3),
        .rem       (),
        .out_pay   ()
    );

    always_comb
    begin
        mode3 = mode_t'(pay3[PAY-2:PAY-3]);
        resh  = 32'(qh3) * 32'(f);
        resw  = 32'(qw3) * 32'(f);
        if (pay3[PAY-1])
        begin
            oh_next = '0;
            ow_next = '0;
        end
        else if (mode3 == MODE_KEEP)
        begin
            oh_next = sat_side(32'(pay3[2*HB-1:HB]));
            ow_next = sat_side(32'(pay3[HB-1:0]));
        end
        else
        begin
            oh_next = sat_side(resh);
            ow_next = sat_side(resw);
        end
    end

    assign out_valid  = ov_reg;
    assign out_height = oh_reg;
    assign out_width  = ow_reg;
    assign out_bad    = ob_reg;

endmodule

// ----- src/image_resize_dimension_planner.sv -----
`timescale 1ns / 1ps
// Top level of the image resize dimension planner: configuration registers,
// front end, queue and back end. Uses irdp_pkg and all irdp_* modules.
//
// The block takes one item per clock cycle while neither stream stalls, and returns
// one result per item, in order. The front and back ends are built from pipelined
// dividers and square-root stages, with the queue between them. Either stream may
// stall; the queue lets the front end keep accepting items while the back end waits.
// The user must write configuration through the cfg port while the block is idle;
// the block itself does not enforce this. The cfg port is always ready.
module image_resize_dimension_planner
    import irdp_pkg::*;
#(
    parameter int DIM_BITS = 14
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [AREA_BITS-1:0]          cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // in_height, in_width, then zero fill
    input  logic [((2*DIM_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // out_height, out_width
    output logic [2*SIDE_BITS-1:0]        m_axis_tdata,
    // bad_shape
    output logic                          m_axis_tuser
);

    localparam int HB = DIM_BITS + 1;
    localparam int QW = 2 * DIM_BITS + 3 + 2 * HB;

    logic [FACTOR_BITS-1:0] factor_reg;
    logic [AREA_BITS-1:0]   min_area_reg;
    logic [AREA_BITS-1:0]   max_area_reg;
    cfg_t                   cfg;

    logic                   fv;
    logic                   fr;
    logic [DIM_BITS-1:0]    fh;
    logic [DIM_BITS-1:0]    fw;
    logic                   fbad;
    mode_t                  fmode;
    logic [HB-1:0]          fhb;
    logic [HB-1:0]          fwb;

    logic                   qv;
    logic                   qr;
    logic [QW-1:0]          qdata;

    logic [SIDE_BITS-1:0]   oh;
    logic [SIDE_BITS-1:0]   ow;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factor_reg   <= RESET_FACTOR;
            min_area_reg <= RESET_MIN_AREA;
            max_area_reg <= RESET_MAX_AREA;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_GRID_FACTOR: factor_reg   <= cfg_data[FACTOR_BITS-1:0];
                CFG_MIN_AREA:    min_area_reg <= cfg_data;
                CFG_MAX_AREA:    max_area_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign cfg = '{factor: factor_reg, min_area: min_area_reg, max_area: max_area_reg};

    irdp_front #(.DIM_BITS(DIM_BITS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_h      (s_axis_tdata[DIM_BITS-1:0]),
        .in_w      (s_axis_tdata[2*DIM_BITS-1:DIM_BITS]),
        .out_valid (fv),
        .out_ready (fr),
        .out_h     (fh),
        .out_w     (fw),
        .out_bad   (fbad),
        .out_mode  (fmode),
        .out_hb    (fhb),
        .out_wb    (fwb)
    );

    irdp_fifo #(.W(QW)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fv),
        .in_ready  (fr),
        .in_data   ({fh, fw, fbad, fmode, fhb, fwb}),
        .out_valid (qv),
        .out_ready (qr),
        .out_data  (qdata)
    );

    irdp_back #(.DIM_BITS(DIM_BITS)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (qv),
        .in_ready   (qr),
        .in_h       (qdata[QW-1:QW-DIM_BITS]),
        .in_w       (qdata[QW-DIM_BITS-1:2*HB+3]),
        .in_bad     (qdata[2*HB+2]),
        .in_mode    (mode_t'(qdata[2*HB+1:2*HB])),
        .in_hb      (qdata[2*HB-1:HB]),
        .in_wb      (qdata[HB-1:0]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_height (oh),
        .out_width  (ow),
        .out_bad    (m_axis_tuser)
    );

    assign m_axis_tdata = {ow, oh};

endmodule
